>>> src/km_pkg.sv
package km_pkg;

	localparam int MAX_POINTS   = 64;
	localparam int MAX_CLUSTERS = 8;
	localparam int ROUNDS       = 3;

	localparam int COORD_W = 16;
	localparam int PT_AW   = $clog2(MAX_POINTS);
	localparam int CNT_W   = $clog2(MAX_POINTS + 1);
	localparam int CL_W    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int K_W     = $clog2(MAX_CLUSTERS + 1);
	localparam int RND_W   = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
	localparam int SUM_W   = COORD_W + CNT_W - 1;
	localparam int SQ_W    = 2 * COORD_W + 1;
	localparam int DIST_W  = SQ_W + 1;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CLR,
		ST_PRD,
		ST_PLAT,
		ST_DX,
		ST_DY,
		ST_CMP,
		ST_ACC,
		ST_DGO,
		ST_DWX,
		ST_DWY,
		ST_ORD,
		ST_OCHK,
		ST_OHOLD
	} km_state_t;

endpackage

>>> src/km_ram.sv
module km_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/km_div.sv
// Restoring divider: signed sum over unsigned member count, one quotient bit
// per cycle, quotient truncated toward zero.
module km_div
	import km_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [SUM_W-1:0]   dividend,
	input  logic [CNT_W-1:0]          divisor,
	output logic                      done,
	output logic signed [COORD_W-1:0] quot
);

	localparam int STEP_W = $clog2(SUM_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [CNT_W:0]    rem_q;
	logic [SUM_W-1:0]  q_q;
	logic [CNT_W:0]    rem_sh;
	logic              fits;
	logic [SUM_W-1:0]  q_signed;

	assign rem_sh   = {rem_q[CNT_W-1:0], q_q[SUM_W-1]};
	assign fits     = rem_sh >= {1'b0, dvs_q};
	assign q_signed = neg_q ? (~q_q + SUM_W'(1)) : q_q;
	assign quot     = q_signed[COORD_W-1:0];
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			q_q   <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			q_q   <= {q_q[SUM_W-2:0], fits};
		end
	end

endmodule

>>> src/kmeans_lloyd_2d.sv
// Channel   Handshake               Payload
// in        in_valid / in_ready     coord_x, coord_y, seed_mark, last_point
// out       out_valid / out_ready   cluster_id, out_x, out_y, last_result, overflow
// cfg       cfg_wr_en               cfg_wr_data (num_clusters)
//
// Loading accepts one word per cycle. The last point starts ROUNDS rounds; a
// round clears the sums and counts, then per point reads and latches it, computes
// dx, dy and the compare for each centroid, then accumulates; then each non-empty
// centroid takes two divisions on the shared divider, and each empty one
// collapses to the origin. Emission scans the point store once per cluster,
// reading and checking each point, and holds each point sent while out_ready is low.
// arst_n clears the control state, the centroids and the cluster count (2).
// in_ready is high only while loading; out_valid holds until taken.
module kmeans_lloyd_2d
	import km_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [15:0]        coord_x,
	input  logic signed [15:0]        coord_y,
	input  logic                      seed_mark,
	input  logic                      last_point,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [2:0]                cluster_id,
	output logic signed [15:0]        out_x,
	output logic signed [15:0]        out_y,
	output logic                      last_result,
	output logic                      overflow,
	input  logic                      cfg_wr_en,
	input  logic [3:0]                cfg_wr_data
);

	km_state_t state_q, state_d;

	logic [3:0]               nc_q;
	logic [K_W-1:0]           k_q;
	logic [K_W-1:0]           k_new;
	logic [CNT_W-1:0]         n_q;
	logic [K_W-1:0]           seeds_q;
	logic                     dropped_q;
	logic [CNT_W-1:0]         i_q;
	logic [CL_W-1:0]          c_q;
	logic [RND_W-1:0]         rnd_q;
	logic [CNT_W-1:0]         emit_q;

	logic signed [COORD_W-1:0] cent_x_q [MAX_CLUSTERS];
	logic signed [COORD_W-1:0] cent_y_q [MAX_CLUSTERS];
	logic signed [SUM_W-1:0]   sum_x_q  [MAX_CLUSTERS];
	logic signed [SUM_W-1:0]   sum_y_q  [MAX_CLUSTERS];
	logic [CNT_W-1:0]          mcnt_q   [MAX_CLUSTERS];

	logic signed [COORD_W-1:0] px_q, py_q;
	logic [SQ_W-1:0]           sqx_q, sqy_q;
	logic [DIST_W-1:0]         best_q;
	logic [CL_W-1:0]           bestc_q;

	// datapath helpers
	logic                      in_acc;
	logic                      last_c;
	logic                      last_i;
	logic [CL_W-1:0]           sel;
	logic signed [COORD_W:0]   diff;
	logic signed [2*COORD_W+1:0] prod;
	logic [DIST_W-1:0]         dist_sum;

	// memories and divider
	logic                      pt_we, rd_en, asg_we;
	logic [2*COORD_W-1:0]      pt_rd;
	logic [CL_W-1:0]           asg_rd;
	logic                      div_start, div_done;
	logic signed [SUM_W-1:0]   div_num;
	logic signed [COORD_W-1:0] div_q;

	assign in_acc = in_valid && in_ready;
	assign last_c = ({1'b0, c_q} == K_W'(k_q - K_W'(1))) || (K_W'(c_q) == k_q - K_W'(1));
	assign last_i = (i_q + CNT_W'(1)) == n_q;
	assign sel    = (state_q == ST_ACC) ? bestc_q : c_q;

	always_comb begin
		if (nc_q == '0) begin
			k_new = K_W'(1);
		end else if (int'(nc_q) > MAX_CLUSTERS) begin
			k_new = K_W'(MAX_CLUSTERS);
		end else begin
			k_new = K_W'(nc_q);
		end
	end

	// one shared squarer: dx in ST_DX, dy in ST_DY
	assign diff = (state_q == ST_DX)
		? ({px_q[COORD_W-1], px_q} - {cent_x_q[c_q][COORD_W-1], cent_x_q[c_q]})
		: ({py_q[COORD_W-1], py_q} - {cent_y_q[c_q][COORD_W-1], cent_y_q[c_q]});
	assign prod = diff * diff;
	assign dist_sum = {1'b0, sqx_q} + {1'b0, sqy_q};

	assign div_num = (state_q == ST_DGO) ? sum_x_q[sel] : sum_y_q[sel];

	km_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_POINTS)) u_pt_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (n_q[PT_AW-1:0]),
		.wdata ({coord_x, coord_y}),
		.re    (rd_en),
		.raddr (i_q[PT_AW-1:0]),
		.rdata (pt_rd)
	);

	km_ram #(.WIDTH(CL_W), .DEPTH(MAX_POINTS)) u_asg_ram (
		.clk   (clk),
		.we    (asg_we),
		.waddr (i_q[PT_AW-1:0]),
		.wdata (bestc_q),
		.re    (rd_en),
		.raddr (i_q[PT_AW-1:0]),
		.rdata (asg_rd)
	);

	km_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (mcnt_q[sel]),
		.done     (div_done),
		.quot     (div_q)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:  if (in_acc && last_point) state_d = ST_CLR;
			ST_CLR:   state_d = ST_PRD;
			ST_PRD:   state_d = ST_PLAT;
			ST_PLAT:  state_d = ST_DX;
			ST_DX:    state_d = ST_DY;
			ST_DY:    state_d = ST_CMP;
			ST_CMP:   state_d = last_c ? ST_ACC : ST_DX;
			ST_ACC:   state_d = last_i ? ST_DGO : ST_PRD;
			ST_DGO: begin
				if (mcnt_q[sel] != '0) begin
					state_d = ST_DWX;
				end else if (last_c) begin
					state_d = (int'(rnd_q) == ROUNDS - 1) ? ST_ORD : ST_CLR;
				end
			end
			ST_DWX:   if (div_done) state_d = ST_DWY;
			ST_DWY: begin
				if (div_done) begin
					if (!last_c) begin
						state_d = ST_DGO;
					end else begin
						state_d = (int'(rnd_q) == ROUNDS - 1) ? ST_ORD : ST_CLR;
					end
				end
			end
			ST_ORD:   state_d = ST_OCHK;
			ST_OCHK:  state_d = (asg_rd == c_q) ? ST_OHOLD : ST_ORD;
			ST_OHOLD: begin
				if (out_ready) begin
					state_d = (emit_q == n_q - CNT_W'(1)) ? ST_LOAD : ST_ORD;
				end
			end
			default:  state_d = ST_LOAD;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready  = (state_q == ST_LOAD);
		out_valid = (state_q == ST_OHOLD);
		pt_we     = in_acc && (int'(n_q) < MAX_POINTS);
		rd_en     = (state_q == ST_PRD) || (state_q == ST_ORD);
		asg_we    = (state_q == ST_ACC);
		div_start = ((state_q == ST_DGO) && (mcnt_q[sel] != '0))
			|| ((state_q == ST_DWX) && div_done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			nc_q    <= 4'd2;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				nc_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			seeds_q   <= '0;
			dropped_q <= 1'b0;
			k_q       <= K_W'(1);
			i_q       <= '0;
			c_q       <= '0;
			rnd_q     <= '0;
			emit_q    <= '0;
			for (int j = 0; j < MAX_CLUSTERS; j++) begin
				cent_x_q[j] <= '0;
				cent_y_q[j] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						// store the word, or drop it once the store is full
						if (int'(n_q) < MAX_POINTS) begin
							n_q <= n_q + CNT_W'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (seed_mark && (int'(seeds_q) < MAX_CLUSTERS)) begin
							cent_x_q[seeds_q[CL_W-1:0]] <= coord_x;
							cent_y_q[seeds_q[CL_W-1:0]] <= coord_y;
							seeds_q <= seeds_q + K_W'(1);
						end
						if (last_point) begin
							k_q   <= k_new;
							rnd_q <= '0;
						end
					end
				end
				ST_CLR: begin
					i_q <= '0;
				end
				ST_PLAT: begin
					c_q <= '0;
				end
				ST_CMP: begin
					if (!last_c) begin
						c_q <= c_q + CL_W'(1);
					end
				end
				ST_ACC: begin
					if (last_i) begin
						c_q <= '0;
					end else begin
						i_q <= i_q + CNT_W'(1);
					end
				end
				ST_DGO: begin
					if (mcnt_q[sel] == '0) begin
						// empty cluster collapses to the origin
						cent_x_q[c_q] <= '0;
						cent_y_q[c_q] <= '0;
						if (!last_c) begin
							c_q <= c_q + CL_W'(1);
						end else begin
							rnd_q  <= rnd_q + RND_W'(1);
							c_q    <= '0;
							i_q    <= '0;
							emit_q <= '0;
						end
					end
				end
				ST_DWX: begin
					if (div_done) begin
						cent_x_q[c_q] <= div_q;
					end
				end
				ST_DWY: begin
					if (div_done) begin
						cent_y_q[c_q] <= div_q;
						if (!last_c) begin
							c_q <= c_q + CL_W'(1);
						end else begin
							rnd_q  <= rnd_q + RND_W'(1);
							c_q    <= '0;
							i_q    <= '0;
							emit_q <= '0;
						end
					end
				end
				ST_OCHK: begin
					if (asg_rd != c_q) begin
						if (last_i) begin
							i_q <= '0;
							c_q <= c_q + CL_W'(1);
						end else begin
							i_q <= i_q + CNT_W'(1);
						end
					end
				end
				ST_OHOLD: begin
					if (out_ready) begin
						emit_q <= emit_q + CNT_W'(1);
						if (emit_q == n_q - CNT_W'(1)) begin
							// run done: start a fresh data set
							n_q       <= '0;
							seeds_q   <= '0;
							dropped_q <= 1'b0;
							for (int j = 0; j < MAX_CLUSTERS; j++) begin
								cent_x_q[j] <= '0;
								cent_y_q[j] <= '0;
							end
						end else if (last_i) begin
							i_q <= '0;
							c_q <= c_q + CL_W'(1);
						end else begin
							i_q <= i_q + CNT_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// accumulators, distance pipeline and output word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_CLR: begin
				for (int j = 0; j < MAX_CLUSTERS; j++) begin
					sum_x_q[j] <= '0;
					sum_y_q[j] <= '0;
					mcnt_q[j]  <= '0;
				end
			end
			ST_PLAT: begin
				px_q <= pt_rd[2*COORD_W-1:COORD_W];
				py_q <= pt_rd[COORD_W-1:0];
			end
			ST_DX: sqx_q <= prod[SQ_W-1:0];
			ST_DY: sqy_q <= prod[SQ_W-1:0];
			ST_CMP: begin
				// strict compare keeps the lower index on a tie
				if (c_q == '0 || dist_sum < best_q) begin
					best_q  <= dist_sum;
					bestc_q <= c_q;
				end
			end
			ST_ACC: begin
				sum_x_q[sel] <= sum_x_q[sel] + SUM_W'(px_q);
				sum_y_q[sel] <= sum_y_q[sel] + SUM_W'(py_q);
				mcnt_q[sel]  <= mcnt_q[sel] + CNT_W'(1);
			end
			ST_OCHK: begin
				cluster_id  <= 3'(c_q);
				out_x       <= pt_rd[2*COORD_W-1:COORD_W];
				out_y       <= pt_rd[COORD_W-1:0];
				last_result <= (emit_q == n_q - CNT_W'(1));
				overflow    <= dropped_q;
			end
			default: begin
			end
		endcase
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output sides active together");

	a_store_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(n_q) <= MAX_POINTS)
		else $error("point count beyond store depth");

	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |-> (K_W'(bestc_q) < k_q))
		else $error("nearest centroid outside active cluster count");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (emit_q < n_q))
		else $error("more words emitted than points stored");

endmodule

>>> tb/sv/kmeans_checker.sv
module kmeans_checker
	import km_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [15:0] coord_x,
	input  logic signed [15:0] coord_y,
	input  logic               seed_mark,
	input  logic               last_point,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [2:0]         cluster_id,
	input  logic signed [15:0] out_x,
	input  logic signed [15:0] out_y,
	input  logic               last_result,
	input  logic               overflow,
	input  logic               cfg_wr_en,
	input  logic [3:0]         cfg_wr_data,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]         cid;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               last;
		logic               ovf;
	} member_t;

	member_t            grouped_points[$];
	logic signed [15:0] pt_x[MAX_POINTS];
	logic signed [15:0] pt_y[MAX_POINTS];
	logic [2:0]         pt_cl[MAX_POINTS];
	logic signed [15:0] cen_x[MAX_CLUSTERS];
	logic signed [15:0] cen_y[MAX_CLUSTERS];
	int                 n_loaded;
	int                 n_seeds;
	bit                 dropped;
	logic [3:0]         k_reg;

	assign pending = grouped_points.size();

	// run the Lloyd rounds on the stored set and queue the grouped points
	task automatic cluster_set();
		int     k, n_out;
		longint sx[MAX_CLUSTERS];
		longint sy[MAX_CLUSTERS];
		int     cnt[MAX_CLUSTERS];
		longint dx, dy, d, best_d;
		int     best;
		member_t m;
		k = (k_reg == 0) ? 1 : ((k_reg > MAX_CLUSTERS) ? MAX_CLUSTERS : k_reg);
		for (int r = 0; r < ROUNDS; r++) begin
			for (int c = 0; c < k; c++) begin
				sx[c] = 0; sy[c] = 0; cnt[c] = 0;
			end
			for (int i = 0; i < n_loaded; i++) begin
				best = 0;
				for (int c = 0; c < k; c++) begin
					dx = longint'(pt_x[i]) - longint'(cen_x[c]);
					dy = longint'(pt_y[i]) - longint'(cen_y[c]);
					d = dx * dx + dy * dy;
					// strict less keeps the lower index on ties
					if (c == 0 || d < best_d) begin
						best_d = d;
						best = c;
					end
				end
				pt_cl[i] = best[2:0];
				sx[best] += pt_x[i];
				sy[best] += pt_y[i];
				cnt[best]++;
			end
			for (int c = 0; c < k; c++) begin
				if (cnt[c] == 0) begin
					cen_x[c] = '0;
					cen_y[c] = '0;
				end else begin
					cen_x[c] = 16'(sx[c] / cnt[c]);
					cen_y[c] = 16'(sy[c] / cnt[c]);
				end
			end
		end
		n_out = 0;
		for (int c = 0; c < k; c++)
			for (int i = 0; i < n_loaded; i++)
				if (pt_cl[i] == c[2:0]) begin
					m.cid = c[2:0];
					m.x = pt_x[i];
					m.y = pt_y[i];
					m.last = 1'b0;
					m.ovf = dropped;
					grouped_points = {grouped_points, m};
					n_out++;
				end
		if (n_out > 0) grouped_points[grouped_points.size() - 1].last = 1'b1;
		n_loaded = 0;
		n_seeds = 0;
		dropped = 0;
		for (int c = 0; c < MAX_CLUSTERS; c++) begin
			cen_x[c] = '0;
			cen_y[c] = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		member_t e;
		if (!arst_n) begin
			n_loaded = 0;
			n_seeds = 0;
			dropped = 0;
			k_reg = 4'd2;
			fail_count = 0;
			for (int c = 0; c < MAX_CLUSTERS; c++) begin
				cen_x[c] = '0;
				cen_y[c] = '0;
			end
		end else begin
			if (cfg_wr_en) k_reg = cfg_wr_data;
			if (out_valid && out_ready) begin
				if (grouped_points.size() == 0) begin
					$error("unexpected output word: cluster_id=%0d x=%0d y=%0d",
						cluster_id, out_x, out_y);
					fail_count++;
				end else begin
					e = grouped_points.pop_front();
					if (cluster_id !== e.cid) begin
						$error("cluster_id: expected %0d, got %0d", e.cid, cluster_id);
						fail_count++;
					end
					if (out_x !== e.x) begin
						$error("out_x: expected %0d, got %0d", e.x, out_x);
						fail_count++;
					end
					if (out_y !== e.y) begin
						$error("out_y: expected %0d, got %0d", e.y, out_y);
						fail_count++;
					end
					if (last_result !== e.last) begin
						$error("last_result: expected %0d, got %0d", e.last, last_result);
						fail_count++;
					end
					if (overflow !== e.ovf) begin
						$error("overflow: expected %0d, got %0d", e.ovf, overflow);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (n_loaded < MAX_POINTS) begin
					pt_x[n_loaded] = coord_x;
					pt_y[n_loaded] = coord_y;
					n_loaded++;
				end else begin
					dropped = 1;
				end
				// a seed counts even when the point itself is dropped
				if (seed_mark && n_seeds < MAX_CLUSTERS) begin
					cen_x[n_seeds] = coord_x;
					cen_y[n_seeds] = coord_y;
					n_seeds++;
				end
				if (last_point) cluster_set();
			end
		end
	end
endmodule

>>> tb/sv/tb_top.sv
module tb_top
	import km_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [15:0] coord_x = '0;
	logic signed [15:0] coord_y = '0;
	logic               seed_mark = 1'b0;
	logic               last_point = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         cluster_id;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic               last_result;
	logic               overflow;
	logic               cfg_wr_en = 1'b0;
	logic [3:0]         cfg_wr_data = '0;
	int                 fail_count;
	int                 pending;

	// burst state of the point sender
	int burst_left = 0;
	int words_sent = 0;

	always #5 clk = ~clk;

	kmeans_lloyd_2d dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.coord_x(coord_x), .coord_y(coord_y),
		.seed_mark(seed_mark), .last_point(last_point),
		.out_valid(out_valid), .out_ready(out_ready),
		.cluster_id(cluster_id), .out_x(out_x), .out_y(out_y),
		.last_result(last_result), .overflow(overflow),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	kmeans_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.coord_x(coord_x), .coord_y(coord_y),
		.seed_mark(seed_mark), .last_point(last_point),
		.out_valid(out_valid), .out_ready(out_ready),
		.cluster_id(cluster_id), .out_x(out_x), .out_y(out_y),
		.last_result(last_result), .overflow(overflow),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.fail_count(fail_count), .pending(pending)
	);

	// Receiver: switch between always-ready, coin-flip and sparse-ready
	// stretches so that stalls land on every phase of the emission scan.
	int stall_mode = 0;
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(8, 80);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= $urandom_range(0, 1);
			end
			default: begin
				out_ready <= ($urandom_range(0, 3) == 0);
			end
		endcase
	end

	// Send one point word; hold it until in_ready is seen. Ready is checked
	// at the falling edge, where nothing the block drives is still moving.
	task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic s, input logic l);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		coord_x <= x;
		coord_y <= y;
		seed_mark <= s;
		last_point <= l;
		forever begin
			@(negedge clk);
			if (in_ready) break;
		end
		@(posedge clk);
		words_sent++;
		// drop valid after the last word of a set; the block leaves loading
		if (l) begin
			in_valid <= 1'b0;
			burst_left = 0;
		end
	endtask

	// Wait until every expected word is out, plus the tail of the output scan.
	task automatic drain();
		forever begin
			@(negedge clk);
			if (pending == 0) break;
		end
		repeat (200) @(posedge clk);
	endtask

	task automatic write_k(input logic [3:0] v);
		drain();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic signed [15:0] near(input int c, input int spread);
		int v;
		v = c + $urandom_range(0, 2 * spread) - spread;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	// random data set: clustered points around a few centers, some noise
	task automatic random_set(input int n_pts, input int seed_pct);
		int cx[8];
		int cy[8];
		int n_ctr, spread, c;
		logic signed [15:0] x, y;
		n_ctr = $urandom_range(1, 8);
		spread = ($urandom_range(0, 1) == 0) ? 300 : $urandom_range(1, 20000);
		for (int i = 0; i < n_ctr; i++) begin
			cx[i] = $signed(16'($urandom));
			cy[i] = $signed(16'($urandom));
		end
		for (int i = 0; i < n_pts; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				x = 16'($urandom);
				y = 16'($urandom);
			end else begin
				c = $urandom_range(0, n_ctr - 1);
				x = near(cx[c], spread);
				y = near(cy[c], spread);
			end
			send_point(x, y, $urandom_range(0, 99) < seed_pct, i == n_pts - 1);
		end
	endtask

	initial begin
		int n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// extremes of both coordinates, reset cluster count of two
		send_point(-16'sd32768, 16'sd32767, 1, 0);
		send_point(16'sd32767, -16'sd32768, 1, 0);
		send_point(16'sd0, 16'sd0, 0, 0);
		send_point(-16'sd32768, -16'sd32768, 0, 0);
		send_point(16'sd32767, 16'sd32767, 0, 1);

		// single cluster, no seed: the centroid starts at the origin
		write_k(4'd1);
		send_point(16'sd100, 16'sd100, 0, 0);
		send_point(-16'sd100, -16'sd100, 0, 0);
		send_point(16'sd5, 16'sd5, 0, 1);

		// eight clusters: equal distances, duplicate seeds leave clusters empty
		write_k(4'd8);
		send_point(-16'sd10, 16'sd0, 1, 0);
		send_point(16'sd10, 16'sd0, 1, 0);
		send_point(16'sd10, 16'sd0, 1, 0);
		send_point(16'sd0, 16'sd0, 0, 0);
		send_point(16'sd0, 16'sd5, 0, 0);
		send_point(-16'sd7, 16'sd9, 0, 1);

		// count zero acts as one cluster
		write_k(4'd0);
		send_point(16'sd300, -16'sd300, 1, 0);
		send_point(-16'sd1, 16'sd1, 0, 1);

		// count above the maximum saturates; six seeds for eight clusters
		write_k(4'd15);
		for (int i = 0; i < 6; i++)
			send_point(16'(i * 4000 - 12000), 16'(12000 - i * 3000), 1, i == 5);

		// random sets, with one full store and one overfilled store
		n = 0;
		while (words_sent < 330) begin
			write_k(4'($urandom_range(0, 15)));
			if (n == 3) random_set(64, 15);
			else if (n == 7) random_set(70, 20);
			else if ($urandom_range(0, 7) == 0) random_set($urandom_range(15, 40), 30);
			else random_set($urandom_range(1, 14), $urandom_range(0, 60));
			n++;
		end
		write_k(4'd8);
		random_set(10, 100);

		drain();
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
